// ===== hw/rtl/line_inlier_axis_selector_assert.svh =====
// Assertion macros for the line inlier axis selector RTL.
`ifndef LINE_INLIER_AXIS_SELECTOR_ASSERT_SVH
`define LINE_INLIER_AXIS_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LIAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LIAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lias_pkg.sv =====
// Package with types and constants of the line inlier axis selector.
`default_nettype none

package lias_pkg;

  // Field and register widths
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int AXES         = 3;
  localparam int AXIS_W       = 2;
  localparam int AXIS_REG_W   = 3 * COORD_W;
  localparam int RADIUS_W     = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int BEST_COUNT_W = 20;
  localparam int COUNT_BITS_DEF = 20;

  // Shared multiplier operand and product widths
  localparam int OPW   = 24;
  localparam int PRODW = 2 * OPW;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_ZERO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_ONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_TWO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INLIER_RAD  = 3'd4;

  // Reset values: unit x, y and z axes in Q1.14
  localparam logic [AXIS_REG_W-1:0] AXIS_ZERO_RST = 48'h0000_0000_4000;
  localparam logic [AXIS_REG_W-1:0] AXIS_ONE_RST  = 48'h0000_4000_0000;
  localparam logic [AXIS_REG_W-1:0] AXIS_TWO_RST  = 48'h4000_0000_0000;

  localparam logic [BEST_COUNT_W-1:0] BEST_COUNT_MAX = '1;

  typedef logic signed [OPW-1:0]   opnd_t;
  typedef logic signed [PRODW-1:0] prod_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;
  } in_t;

  typedef struct packed {
    logic [AXIS_W-1:0]         best_axis;
    logic [BEST_COUNT_W-1:0]   best_count;
    logic signed [COORD_W-1:0] best_axis_x;
    logic signed [COORD_W-1:0] best_axis_y;
    logic signed [COORD_W-1:0] best_axis_z;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/line_inlier_axis_selector.sv =====
// Top level of the line inlier axis selector.
// Counts, for each of three configured axis lines through a common origin,
// the points that lie within the inlier radius, and on the point marked last
// reports the axis with the most inliers, its count and its components, then
// clears the counters. A point is taken in the idle cycle and then runs five
// steps per axis through one shared three-lane multiplier (dot product,
// rescale, projection, residual square, compare); a last point then loads the
// result register, held back while an unread earlier result stays. The result
// register parts the two sides, so the result waits there while the next point
// runs. Configuration is written through cfg_we/cfg_index/cfg_wdata; the user
// must write it only while idle: the block itself does not enforce this.
`default_nettype none

`include "line_inlier_axis_selector_assert.svh"

module line_inlier_axis_selector #(
  parameter int COUNT_BITS = lias_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire lias_pkg::in_t                        in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output lias_pkg::out_t                            out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [lias_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lias_pkg::AXIS_REG_W-1:0]      cfg_wdata
);

  localparam int CW = COUNT_BITS + lias_pkg::BEST_COUNT_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DOT  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_PROJ = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [lias_pkg::AXIS_W-1:0] axis_idx_r, axis_idx_nxt;

  logic [lias_pkg::AXIS_REG_W-1:0] axis_r [lias_pkg::AXES];
  logic [lias_pkg::AXIS_REG_W-1:0] origin_r;
  logic [lias_pkg::RADIUS_W-1:0]   radius_r;
  logic [2*lias_pkg::RADIUS_W-1:0] lim_r;

  logic signed [lias_pkg::DIFF_W-1:0] d_r [lias_pkg::AXES];
  logic                               last_r;
  logic signed [20:0]                 s10_r;
  logic [COUNT_BITS-1:0]              cnt_r [lias_pkg::AXES];

  logic            out_valid_r;
  lias_pkg::out_t  out_r;

  lias_pkg::opnd_t op_a [lias_pkg::AXES];
  lias_pkg::opnd_t op_b [lias_pkg::AXES];
  lias_pkg::prod_t prod [lias_pkg::AXES];
  logic            mul_ce;

  logic                         in_acc;
  logic                         out_free;
  logic                         fin_load;
  logic                         is_last_axis;
  logic signed [35:0]           s_sum;
  logic signed [35:0]           s_rnd;
  logic [49:0]                  sq;
  logic                         inlier;
  logic [lias_pkg::AXIS_REG_W-1:0] cur_axis;
  logic [lias_pkg::AXIS_W-1:0]  best;
  logic [COUNT_BITS-1:0]        maxc;
  logic [CW-1:0]                maxc_ext;
  logic [lias_pkg::BEST_COUNT_W-1:0] best_cnt;

  assign in_ready     = (state_r == S_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign fin_load     = (state_r == S_FIN) && out_free;
  assign is_last_axis = (axis_idx_r == lias_pkg::AXIS_W'(lias_pkg::AXES - 1));
  assign cur_axis     = axis_r[axis_idx_r];

  // Rescale the dot product to Q.10, rounded half up
  always_comb begin
    s_sum = prod[0][35:0] + prod[1][35:0] + prod[2][35:0];
    s_rnd = s_sum + 36'sd8192;
  end

  // Select operands of the shared multiplier for the current step
  always_comb begin
    logic signed [37:0] p_rnd;
    logic signed [22:0] p_q;
    logic signed [23:0] r_q;
    p_rnd = '0;
    p_q   = '0;
    r_q   = '0;
    for (int k = 0; k < lias_pkg::AXES; k++) begin
      p_rnd   = prod[k][37:0] + 38'sd8192;
      p_q     = p_rnd[36:14];
      r_q     = {{(24 - lias_pkg::DIFF_W){d_r[k][lias_pkg::DIFF_W-1]}}, d_r[k]}
              - {p_q[22], p_q};
      op_a[k] = '0;
      op_b[k] = '0;
      unique case (state_r)
        S_DOT: begin
          op_a[k] = {{(lias_pkg::OPW - lias_pkg::DIFF_W){d_r[k][lias_pkg::DIFF_W-1]}},
                     d_r[k]};
          op_b[k] = {{(lias_pkg::OPW - lias_pkg::COORD_W){cur_axis[16*k+15]}},
                     cur_axis[16*k +: 16]};
        end
        S_PROJ: begin
          op_a[k] = {{(lias_pkg::OPW - 21){s10_r[20]}}, s10_r};
          op_b[k] = {{(lias_pkg::OPW - lias_pkg::COORD_W){cur_axis[16*k+15]}},
                     cur_axis[16*k +: 16]};
        end
        S_RES: begin
          op_a[k] = r_q;
          op_b[k] = r_q;
        end
        default: begin
          op_a[k] = '0;
          op_b[k] = '0;
        end
      endcase
    end
  end

  assign mul_ce = (state_r == S_DOT) || (state_r == S_PROJ) || (state_r == S_RES);

  lias_mul3 u_mul (
    .clk  (clk),
    .ce   (mul_ce),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Sum the squared residuals and test against the squared radius
  always_comb begin
    sq = '0;
    for (int k = 0; k < lias_pkg::AXES; k++) begin
      sq = sq + {2'b00, prod[k]};
    end
    inlier = (sq <= {18'd0, lim_r});
  end

  // Pick the winner: ties go to the earlier axis, a zero best is replaced
  always_comb begin
    best = '0;
    maxc = '0;
    for (int i = 0; i < lias_pkg::AXES; i++) begin
      if (maxc == '0 || cnt_r[i] > maxc) begin
        best = lias_pkg::AXIS_W'(i);
        maxc = cnt_r[i];
      end
    end
    maxc_ext = CW'(maxc);
    if (maxc_ext > CW'(lias_pkg::BEST_COUNT_MAX)) begin
      best_cnt = lias_pkg::BEST_COUNT_MAX;
    end else begin
      best_cnt = maxc_ext[lias_pkg::BEST_COUNT_W-1:0];
    end
  end

  // Advance the sequencer
  always_comb begin
    state_nxt    = state_r;
    axis_idx_nxt = axis_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt    = S_DOT;
          axis_idx_nxt = '0;
        end
      end
      S_DOT:  state_nxt = S_NORM;
      S_NORM: state_nxt = S_PROJ;
      S_PROJ: state_nxt = S_RES;
      S_RES:  state_nxt = S_CMP;
      S_CMP: begin
        if (!is_last_axis) begin
          state_nxt    = S_DOT;
          axis_idx_nxt = axis_idx_r + 1'b1;
        end else if (last_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      axis_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      axis_idx_r <= axis_idx_nxt;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r[0] <= lias_pkg::AXIS_ZERO_RST;
      axis_r[1] <= lias_pkg::AXIS_ONE_RST;
      axis_r[2] <= lias_pkg::AXIS_TWO_RST;
      origin_r  <= '0;
      radius_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lias_pkg::REG_AXIS_ZERO:   axis_r[0] <= cfg_wdata;
        lias_pkg::REG_AXIS_ONE:    axis_r[1] <= cfg_wdata;
        lias_pkg::REG_AXIS_TWO:    axis_r[2] <= cfg_wdata;
        lias_pkg::REG_LINE_ORIGIN: origin_r  <= cfg_wdata;
        lias_pkg::REG_INLIER_RAD:  radius_r  <= cfg_wdata[lias_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the squared radius, registered from the radius register
  always_ff @(posedge clk) begin
    lim_r <= radius_r * radius_r;
  end

  // Take the point relative to the origin
  always_ff @(posedge clk) begin
    if (in_acc) begin
      d_r[0] <= lias_pkg::DIFF_W'(in_data.point_x)
              - lias_pkg::DIFF_W'($signed(origin_r[15:0]));
      d_r[1] <= lias_pkg::DIFF_W'(in_data.point_y)
              - lias_pkg::DIFF_W'($signed(origin_r[31:16]));
      d_r[2] <= lias_pkg::DIFF_W'(in_data.point_z)
              - lias_pkg::DIFF_W'($signed(origin_r[47:32]));
      last_r <= in_data.last_point;
    end
  end

  // Hold the rescaled dot product
  always_ff @(posedge clk) begin
    if (state_r == S_NORM) begin
      s10_r <= s_rnd[34:14];
    end
  end

  // Count inliers with saturation, clear after a result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lias_pkg::AXES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (fin_load) begin
      for (int i = 0; i < lias_pkg::AXES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (state_r == S_CMP && inlier && cnt_r[axis_idx_r] != '1) begin
      cnt_r[axis_idx_r] <= cnt_r[axis_idx_r] + 1'b1;
    end
  end

  // Load the result register and drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_r.best_axis   <= best;
      out_r.best_count  <= best_cnt;
      out_r.best_axis_x <= axis_r[best][15:0];
      out_r.best_axis_y <= axis_r[best][31:16];
      out_r.best_axis_z <= axis_r[best][47:32];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LIAS_ASSERT_NXT(a_accept_starts, in_acc, (state_r == S_DOT) && (axis_idx_r == '0), "accepted request did not start at the first axis")
  `LIAS_ASSERT_IMP(a_axis_range, 1'b1, axis_idx_r <= lias_pkg::AXIS_W'(lias_pkg::AXES - 1), "axis index out of range")
  `LIAS_ASSERT_IMP(a_fin_only_last, state_r == S_FIN, last_r, "result stage entered without a last point")
  `LIAS_ASSERT_NXT(a_counts_cleared, fin_load, (cnt_r[0] == '0) && (cnt_r[1] == '0) && (cnt_r[2] == '0), "counters not cleared after result")
  `LIAS_ASSERT_NXT(a_result_loaded, fin_load, out_valid_r, "result register not loaded")

endmodule

`default_nettype wire

// ===== hw/rtl/lias_mul3.sv =====
// Shared three-lane signed multiplier with registered products.
`default_nettype none

module lias_mul3 (
  input  wire logic           clk,
  input  wire logic           ce,
  input  wire lias_pkg::opnd_t op_a [lias_pkg::AXES],
  input  wire lias_pkg::opnd_t op_b [lias_pkg::AXES],
  output lias_pkg::prod_t     prod [lias_pkg::AXES]
);

  lias_pkg::prod_t prod_r [lias_pkg::AXES];

  // Multiply each lane and hold the product until the next enabled cycle
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < lias_pkg::AXES; k++) begin
        prod_r[k] <= op_a[k] * op_b[k];
      end
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the line inlier axis selector.
`timescale 1ns / 100ps

module testbench;
  import lias_pkg::*;

  localparam int unsigned COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_AXIS_ZERO;
  logic [AXIS_REG_W-1:0] cfg_wdata = '0;

  // Shadow copy of the configuration and the per-axis inlier counters
  logic [AXIS_REG_W-1:0] axis_cfg [AXES];
  logic [AXIS_REG_W-1:0] origin_cfg;
  logic [RADIUS_W-1:0] radius_cfg;
  int unsigned inliers [AXES];

  in_t pending_points [$];
  out_t expected_winners [$];
  int points_queued = 0;
  int points_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int ready_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit steady = 1'b0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  line_inlier_axis_selector DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Signed 16-bit lane k of a packed x/y/z register
  function automatic longint lane(logic [AXIS_REG_W-1:0] v, int k);
    return longint'($signed(v[16*k +: 16]));
  endfunction

  function automatic int rand_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic load_reset_state();
    axis_cfg[0] = AXIS_ZERO_RST;
    axis_cfg[1] = AXIS_ONE_RST;
    axis_cfg[2] = AXIS_TWO_RST;
    origin_cfg = '0;
    radius_cfg = '0;
    for (int i = 0; i < AXES; i++) inliers[i] = 0;
  endtask

  task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [AXIS_REG_W-1:0] data);
    case (idx)
      REG_AXIS_ZERO: axis_cfg[0] = data;
      REG_AXIS_ONE: axis_cfg[1] = data;
      REG_AXIS_TWO: axis_cfg[2] = data;
      REG_LINE_ORIGIN: origin_cfg = data;
      REG_INLIER_RAD: radius_cfg = data[RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  // Count one point against each axis line; on the last point pick the winner
  task automatic tally_point(in_t pt);
    longint d [3];
    longint a [3];
    longint s, s10, proj, resid;
    longint unsigned sq, limit;
    int best;
    int unsigned top;
    out_t win;
    d[0] = longint'(pt.point_x) - lane(origin_cfg, 0);
    d[1] = longint'(pt.point_y) - lane(origin_cfg, 1);
    d[2] = longint'(pt.point_z) - lane(origin_cfg, 2);
    limit = longint'(radius_cfg) * longint'(radius_cfg);
    for (int i = 0; i < AXES; i++) begin
      s = 0;
      for (int k = 0; k < 3; k++) begin
        a[k] = lane(axis_cfg[i], k);
        s += d[k] * a[k];
      end
      s10 = (s + 64'sd8192) >>> 14;
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        proj = (s10 * a[k] + 64'sd8192) >>> 14;
        resid = d[k] - proj;
        sq += longint'(resid * resid);
      end
      if (sq <= limit && inliers[i] < COUNT_MAX) inliers[i]++;
    end
    if (!pt.last_point) return;
    // Ties keep the earlier axis, but a zero best always yields
    best = 0;
    top = 0;
    for (int i = 0; i < AXES; i++) begin
      if (top == 0 || inliers[i] > top) begin
        best = i;
        top = inliers[i];
      end
    end
    if (top > BEST_COUNT_MAX) top = BEST_COUNT_MAX;
    win.best_axis = AXIS_W'(best);
    win.best_count = BEST_COUNT_W'(top);
    win.best_axis_x = axis_cfg[best][15:0];
    win.best_axis_y = axis_cfg[best][31:16];
    win.best_axis_z = axis_cfg[best][47:32];
    expected_winners.insert(expected_winners.size(), win);
    for (int i = 0; i < AXES; i++) inliers[i] = 0;
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (expected_winners.size() == 0) begin
      note_mismatch($sformatf("unexpected result axis %0d count %0d",
                              got.best_axis, got.best_count));
      return;
    end
    want = expected_winners.pop_front();
    if (got.best_axis !== want.best_axis)
      note_mismatch($sformatf("best_axis: expected %0d, got %0d",
                              want.best_axis, got.best_axis));
    if (got.best_count !== want.best_count)
      note_mismatch($sformatf("best_count: expected %0d, got %0d",
                              want.best_count, got.best_count));
    if (got.best_axis_x !== want.best_axis_x)
      note_mismatch($sformatf("best_axis_x: expected %h, got %h",
                              want.best_axis_x, got.best_axis_x));
    if (got.best_axis_y !== want.best_axis_y)
      note_mismatch($sformatf("best_axis_y: expected %h, got %h",
                              want.best_axis_y, got.best_axis_y));
    if (got.best_axis_z !== want.best_axis_z)
      note_mismatch($sformatf("best_axis_z: expected %h, got %h",
                              want.best_axis_z, got.best_axis_z));
  endtask

  // Monitor: sample handshakes, track config writes, check and predict
  always @(posedge clk) begin
    in_taken = (in_valid === 1'b1) && (in_ready === 1'b1);
    out_taken = (out_valid === 1'b1) && (out_ready === 1'b1);
    if (!rst_n) begin
      load_reset_state();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
      if (out_taken) begin
        check_result(out_data);
        results_seen++;
      end
      if (in_taken) begin
        tally_point(in_data);
        points_accepted++;
      end
    end
    if (in_taken || out_taken || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Driver: offer the next request after a random gap, hold until taken
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_points.size() != 0) begin
        in_data <= pending_points.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while requests pile up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 25 && points_queued - points_accepted > 30) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else begin
      if (out_taken || (!steady && $urandom_range(0, 19) == 0)) ready_gap = pick_gap();
      out_ready <= (ready_gap == 0);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AXIS_REG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_point(longint x, longint y, longint z, bit last_flag);
    in_t pt;
    pt.point_x = clamp16(x);
    pt.point_y = clamp16(y);
    pt.point_z = clamp16(z);
    pt.last_point = last_flag;
    pending_points.insert(pending_points.size(), pt);
    points_queued++;
  endtask

  // Point on axis line k, pushed off it by noise scaled to the radius
  task automatic queue_near_point(int k, bit last_flag);
    int t, spread;
    longint c [3];
    t = rand_signed(8000);
    if ($urandom_range(0, 4) != 0) spread = radius_cfg / 2 + 1;
    else spread = 2 * radius_cfg + 8;
    if (spread > 30000) spread = 30000;
    for (int i = 0; i < 3; i++)
      c[i] = lane(origin_cfg, i) + ((longint'(t) * lane(axis_cfg[k], i)) >>> 14)
             + rand_signed(spread);
    queue_point(c[0], c[1], c[2], last_flag);
  endtask

  task automatic queue_cloud();
    int n, fav, roll;
    bit last_flag;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(13, 40);
    else n = $urandom_range(1, 12);
    fav = $urandom_range(0, 2);
    for (int j = 0; j < n; j++) begin
      last_flag = (j == n - 1);
      roll = $urandom_range(0, 99);
      if (roll < 45) queue_near_point(fav, last_flag);
      else if (roll < 65) queue_near_point($urandom_range(0, 2), last_flag);
      else if (roll < 72)
        queue_point(lane(origin_cfg, 0), lane(origin_cfg, 1), lane(origin_cfg, 2), last_flag);
      else
        queue_point(longint'($signed(16'($urandom))), longint'($signed(16'($urandom))),
                    longint'($signed(16'($urandom))), last_flag);
    end
  endtask

  // Mostly unit directions, some skewed and some raw bit patterns
  function automatic logic [AXIS_REG_W-1:0] random_axis();
    logic [15:0] c [3];
    int roll, k, n, mag;
    roll = $urandom_range(0, 99);
    if (roll >= 85) return AXIS_REG_W'({$urandom, $urandom});
    for (int i = 0; i < 3; i++) c[i] = 16'(rand_signed(20000));
    if (roll < 60) begin
      k = $urandom_range(0, 2);
      n = $urandom_range(1, 3);
      mag = (n == 1) ? 16384 : (n == 2) ? 11585 : 9459;
      for (int i = 0; i < 3; i++) begin
        if ((n == 1 && i != k) || (n == 2 && i == k)) c[i] = '0;
        else c[i] = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
      end
    end
    return {c[2], c[1], c[0]};
  endfunction

  // Wait for every request to be taken and every result to be checked
  task automatic settle();
    while (points_accepted != points_queued || expected_winners.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int ph, start;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration, zero radius: only exact hits count
    queue_point(0, 0, 0, 1'b1);
    queue_point(5000, 0, 0, 1'b0);
    queue_point(-7000, 0, 0, 1'b1);
    queue_point(0, 0, 300, 1'b1);
    queue_point(0, 1234, 0, 1'b0);
    queue_point(0, 0, 99, 1'b1);
    queue_point(3000, 4000, 5000, 1'b1);
    queue_point(32767, -32768, 32767, 1'b0);
    queue_point(-32768, 32767, -32768, 1'b1);
    queue_point(32767, 0, 0, 1'b0);
    queue_point(-32768, 0, 0, 1'b1);
    queue_point(0, 32767, 0, 1'b0);
    queue_point(-1, -1, -1, 1'b1);
    settle();

    // Radius of one metre: residuals right at and just past the limit
    write_reg(REG_INLIER_RAD, 48'd1024);
    queue_point(2000, 1024, 0, 1'b0);
    queue_point(2000, 0, 1025, 1'b0);
    queue_point(-600, 600, 600, 1'b0);
    queue_point(0, 0, 0, 1'b1);
    settle();

    for (ph = 0; ph < 10; ph++) begin
      steady = (ph % 4 == 3);
      if (ph == 0) begin
        write_reg(REG_AXIS_ZERO, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_AXIS_ONE, 48'h8000_8000_8000);
        write_reg(REG_AXIS_TWO, 48'h0000_0000_0000);
        write_reg(REG_LINE_ORIGIN, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_INLIER_RAD, 48'hFFFF);
      end else if (ph == 1) begin
        write_reg(REG_AXIS_ZERO, 48'h8000_0000_0000);
        write_reg(REG_AXIS_ONE, 48'h0000_7FFF_0000);
        write_reg(REG_AXIS_TWO, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_LINE_ORIGIN, 48'h8000_8000_8000);
        write_reg(REG_INLIER_RAD, 48'h0);
      end else begin
        if ($urandom_range(0, 4) != 0) write_reg(REG_AXIS_ZERO, random_axis());
        if ($urandom_range(0, 6) == 0) write_reg(REG_AXIS_ONE, axis_cfg[0]);
        else write_reg(REG_AXIS_ONE, random_axis());
        if ($urandom_range(0, 4) != 0) write_reg(REG_AXIS_TWO, random_axis());
        if ($urandom_range(0, 4) != 0)
          write_reg(REG_LINE_ORIGIN, {16'(rand_signed(8192)), 16'(rand_signed(8192)),
                                      16'(rand_signed(8192))});
        else
          write_reg(REG_LINE_ORIGIN, AXIS_REG_W'({$urandom, $urandom}));
        case ($urandom_range(0, 9))
          0: write_reg(REG_INLIER_RAD, 48'h0);
          1: write_reg(REG_INLIER_RAD, 48'hFFFF);
          2, 3: write_reg(REG_INLIER_RAD, 48'($urandom_range(0, 65535)));
          default: write_reg(REG_INLIER_RAD, 48'($urandom_range(0, 2048)));
        endcase
      end
      start = points_queued;
      while (points_queued - start < 123) queue_cloud();
      settle();
    end

    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
